// ----- design/isb_pkg.sv -----
// Shared constants and types for the insertion sort batch block.
package isb_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int MAX_COUNT_DEFAULT = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Operation applied to every cell of the chain at once.
    typedef struct packed {
        logic insert;     // place the broadcast key, move larger entries up
        logic shift_out;  // move every entry one place towards cell zero
    } cell_op_t;

endpackage

// ----- design/isb_in_if.sv -----
// Input channel: one batch element per transfer.
interface isb_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [isb_pkg::VALUE_WIDTH-1:0] value;
    logic                                   last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface

// ----- design/isb_out_if.sv -----
// Output channel: one sorted element per transfer.
interface isb_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [isb_pkg::VALUE_WIDTH-1:0] sorted_value;
    logic                                   last_result;
    logic                                   overflow;

    modport source (output valid, output sorted_value, output last_result,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_result,
                    input overflow, output ready);

endinterface

// ----- design/insertion_sort_batch.sv -----
// The first result is offered once the closing transfer has set the drain flag and the
// head cell has been moved into the output register. Throughput: one element per cycle
// while loading, set by the chain of compare cells; the batch then drains at one result
// per cycle while the receiver is ready, during which no element is taken.
// Reset clears the element count and all control flags; output data and cells are not reset.
module insertion_sort_batch #(
    parameter int MAX_COUNT  = isb_pkg::MAX_COUNT_DEFAULT,
    parameter int DATA_WIDTH = isb_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    isb_in_if.sink     item,
    isb_out_if.source  result
);

    localparam int CountWidth = $clog2(MAX_COUNT + 1);

    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic                  drain_reg;
    logic                  drain_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_ovf_reg;
    logic                  out_ovf_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg;
    logic signed [DATA_WIDTH-1:0] out_data_next;

    logic                         accept;
    logic                         full;
    logic                         load_out;
    logic signed [DATA_WIDTH-1:0] key;
    isb_pkg::cell_op_t            op;

    logic signed [DATA_WIDTH-1:0] cell_data [MAX_COUNT];
    logic                         cell_gt   [MAX_COUNT];

    assign item.ready = !drain_reg;
    assign accept     = item.valid && item.ready;
    assign full       = (count_reg == CountWidth'(MAX_COUNT));
    assign load_out   = drain_reg && (!out_valid_reg || result.ready);
    assign key        = DATA_WIDTH'(item.value);

    assign op.insert    = accept && !full;
    assign op.shift_out = load_out;

    generate
        for (genvar i = 0; i < MAX_COUNT; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_data;
            logic                         left_gt;
            logic signed [DATA_WIDTH-1:0] right_data;

            if (i == 0)
            begin : g_head
                assign left_data = key;
                assign left_gt   = 1'b0;
            end
            else
            begin : g_body
                assign left_data = cell_data[i-1];
                assign left_gt   = cell_gt[i-1];
            end

            if (i == MAX_COUNT - 1)
            begin : g_tail
                assign right_data = cell_data[i];
            end
            else
            begin : g_inner
                assign right_data = cell_data[i+1];
            end

            isb_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .occupied   (count_reg > CountWidth'(i)),
                .key        (key),
                .left_data  (left_data),
                .left_gt    (left_gt),
                .right_data (right_data),
                .data       (cell_data[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CountWidth'(1);
            end
            // close the batch: every batch holds at least one entry here
            if (item.last_item)
            begin
                drain_next = 1'b1;
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cell_data[0];
            out_last_next  = (count_reg == CountWidth'(1));
            out_ovf_next   = dropped_reg;
            count_next     = count_reg - CountWidth'(1);
            if (count_reg == CountWidth'(1))
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.sorted_value = isb_pkg::VALUE_WIDTH'($unsigned(out_data_reg));
    assign result.last_result  = out_last_reg;
    assign result.overflow     = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(MAX_COUNT))
        else $error("element count beyond capacity");

    a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_item |=> drain_reg)
        else $error("closing transfer did not start the drain");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> count_reg != '0)
        else $error("draining with an empty chain");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=>
            out_valid_reg && $stable(out_data_reg) && $stable(out_last_reg)
            && $stable(out_ovf_reg))
        else $error("stalled result changed before its transfer");
`endif

endmodule

// ----- design/isb_cell.sv -----
// One cell of the sorting chain: holds a single entry of the sorted store.
module isb_cell #(
    parameter int DATA_WIDTH = isb_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  isb_pkg::cell_op_t            op,
    input  logic                         occupied,
    input  logic signed [DATA_WIDTH-1:0] key,
    input  logic signed [DATA_WIDTH-1:0] left_data,
    input  logic                         left_gt,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic                         gt
);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;

    // An empty cell counts as larger than any key; equal entries stay put.
    assign gt   = !occupied || (data_reg > key);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (op.insert && gt)
        begin
            data_next = left_gt ? left_data : key;
        end
        else if (op.shift_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- bench/insertion_sort_batch_tb.sv -----
// Self-checking testbench for the insertion sort batch block.
`timescale 1ns / 1ps

module insertion_sort_batch_tb;

    localparam int VW       = isb_pkg::VALUE_WIDTH;
    localparam int CAPACITY = isb_pkg::MAX_COUNT_DEFAULT;
    localparam int MAX_LOGGED = 30;

    localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef struct {
        logic signed [VW-1:0] sorted_value;
        logic                 last_result;
        logic                 overflow;
    } sorted_result_t;

    logic clk;
    logic rst_n;

    isb_in_if  item_ch ();
    isb_out_if result_ch ();

    insertion_sort_batch i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Model of the block: the open batch kept in ascending order
    logic signed [VW-1:0] batch_store[$];
    logic                 batch_dropped;
    sorted_result_t       sorted_expected[$];

    int error_count;
    int elements_sent;
    int batches_closed;
    int overflow_batches;
    int results_checked;

    // Traffic shaping for both sides
    bit tx_burst;
    bit rx_steady;
    int stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("insertion_sort_batch verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_LOGGED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void predict_sort(input logic signed [VW-1:0] v, input logic last);
        int pos;
        sorted_result_t r;
        if (batch_store.size() < CAPACITY)
        begin
            // Go after equal entries so that the order stays stable
            pos = batch_store.size();
            while (pos > 0 && batch_store[pos-1] > v)
                pos--;
            batch_store.insert(pos, v);
        end
        else
            batch_dropped = 1'b1;
        elements_sent++;
        if (last)
        begin
            for (int k = 0; k < batch_store.size(); k++)
            begin
                r.sorted_value = batch_store[k];
                r.last_result  = (k == batch_store.size() - 1);
                r.overflow     = batch_dropped;
                sorted_expected.push_back(r);
            end
            if (batch_dropped)
                overflow_batches++;
            batches_closed++;
            batch_store.delete();
            batch_dropped = 1'b0;
        end
    endfunction

    task automatic check_result();
        sorted_result_t want;
        if (sorted_expected.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result value %0d last %b overflow %b",
                result_ch.sorted_value, result_ch.last_result, result_ch.overflow));
        end
        else
        begin
            want = sorted_expected.pop_front();
            results_checked++;
            if (result_ch.sorted_value !== want.sorted_value)
                report_mismatch($sformatf("sorted_value %0d, expected %0d",
                    result_ch.sorted_value, want.sorted_value));
            if (result_ch.last_result !== want.last_result)
                report_mismatch($sformatf("last_result %b, expected %b (value %0d)",
                    result_ch.last_result, want.last_result, want.sorted_value));
            if (result_ch.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %b, expected %b (value %0d)",
                    result_ch.overflow, want.overflow, want.sorted_value));
        end
    endtask

    // Check outputs before predicting: a result never comes from an element
    // taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (item_ch.valid && item_ch.ready)
                predict_sort(item_ch.value, item_ch.last_item);
        end
    end

    // Receiver: mostly ready, short stalls, now and then a long one
    always @(posedge clk)
    begin
        int r;
        if (rx_steady)
        begin
            result_ch.ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                result_ch.ready <= 1'b1;
            else if (r < 92)
            begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    function automatic int next_gap();
        int r;
        if (tx_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return int'($urandom_range(0, 16)) - 8;
            5:
            begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    return VALUE_MIN + $urandom_range(0, 3);
                return VALUE_MAX - $urandom_range(0, 3);
            end
            default: return $urandom;
        endcase
    endfunction

    // Called on the edge of the previous transfer; valid stays high when
    // there is no gap
    task automatic send_item(input logic signed [VW-1:0] v, input logic last);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.value     <= v;
        item_ch.last_item <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Hold the sender until every expected result has been taken
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sorted_expected.size() != 0);
        @(posedge clk);
    endtask

    task automatic test_extremes();
        send_item(VALUE_MAX, 1'b1);
        send_item(VALUE_MIN, 1'b0);
        send_item('0, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item('1, 1'b1);
        wait_drained();
    endtask

    task automatic test_equal_values();
        send_item(4, 1'b0);
        send_item(-4, 1'b0);
        send_item(4, 1'b1);
        wait_drained();
    endtask

    // Seventeen elements: the last one finds the store full and is dropped,
    // yet still closes the batch
    task automatic test_overflow();
        logic signed [VW-1:0] v;
        for (int i = 0; i <= CAPACITY; i++)
        begin
            if (i == 3)
                v = VALUE_MIN;
            else if (i == CAPACITY)
                v = VALUE_MAX;
            else
                v = ((i * 7) % 5) - 2;
            send_item(v, i == CAPACITY);
        end
        wait_drained();
    endtask

    task automatic test_random_batches(input int n_items, input bit full_rate);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
                len = $urandom_range(1, 8);
            else if (r < 16)
                len = $urandom_range(9, CAPACITY);
            else if (r < 18)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 10);
            tx_burst  = full_rate || ($urandom_range(0, 3) == 0);
            rx_steady = full_rate || ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++)
                send_item(pick_value(), k == len - 1);
            sent += len;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        error_count      = 0;
        elements_sent    = 0;
        batches_closed   = 0;
        overflow_batches = 0;
        results_checked  = 0;
        batch_dropped    = 1'b0;
        tx_burst         = 1'b0;
        rx_steady        = 1'b0;

        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.value     <= '0;
        item_ch.last_item <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_equal_values();
        test_overflow();
        test_random_batches(210, 1'b0);
        test_random_batches(85, 1'b1);
        tx_burst  = 1'b0;
        rx_steady = 1'b0;

        item_ch.valid <= 1'b0;
        wait_drained();
        repeat (2 * CAPACITY + 4) @(posedge clk);

        $display("Sorted %0d elements in %0d batches (%0d with dropped elements)",
            elements_sent, batches_closed, overflow_batches);
        $display("Compared %0d results under random gaps, receiver stalls and full-rate runs",
            results_checked);
        if (error_count == 0 && sorted_expected.size() == 0)
            $display("insertion_sort_batch verification clean");
        else
            $display("insertion_sort_batch verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/isb_pkg.sv
design/isb_in_if.sv
design/isb_out_if.sv
design/isb_cell.sv
design/insertion_sort_batch.sv
bench/insertion_sort_batch_tb.sv
